FILE: design/hall_pulse_counter_with_lockout_assert.svh
// Assertion macros shared by the hall pulse counter RTL.
`ifndef HALL_PULSE_COUNTER_WITH_LOCKOUT_ASSERT_SVH
`define HALL_PULSE_COUNTER_WITH_LOCKOUT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define HPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define HPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hpc_pkg.sv
// Types and constants of the hall pulse counter.
package hpc_pkg;

  // Channel count and derived index width
  localparam int Channels = 4;
  localparam int IdxW     = (Channels > 1) ? $clog2(Channels) : 1;

  // Field widths
  localparam int CmdW   = 1;
  localparam int ChanW  = 2;
  localparam int PinW   = 4;
  localparam int CountW = 7;
  localparam int TickW  = 10;

  // Configuration port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // Command codes
  localparam logic [CmdW-1:0] CmdTick = 1'b0;
  localparam logic [CmdW-1:0] CmdEdge = 1'b1;

  // Register indexes, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegConfirm   = 2'd1,
    RegLockout   = 2'd2
  } reg_idx_e;

  // Register reset values
  localparam logic [CountW-1:0] ThresholdRst = 7'd20;
  localparam logic [TickW-1:0]  ConfirmRst   = 10'd3;
  localparam logic [TickW-1:0]  LockoutRst   = 10'd500;

  // Tick counters saturate here
  localparam logic [TickW-1:0] TickMax = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StEdge,
    StVisit,
    StDone
  } state_e;

endpackage

FILE: design/hpc_if.sv
// Valid/ready channel interfaces for input and result transactions.
interface hpc_in_if;
  import hpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [ChanW-1:0]  channel;
  logic [PinW-1:0]   pin_levels;

  modport source (output valid, command, channel, pin_levels, input ready);
  modport sink   (input valid, command, channel, pin_levels, output ready);
endinterface

interface hpc_out_if;
  import hpc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] remaining;
  logic              remaining_updated;
  logic [CountW-1:0] pulse_count;
  logic              output_level;
  logic              lock_active;

  modport source (output valid, remaining, remaining_updated, pulse_count, output_level,
                  lock_active, input ready);
  modport sink   (input valid, remaining, remaining_updated, pulse_count, output_level,
                  lock_active, output ready);
endinterface

FILE: design/hall_pulse_counter_with_lockout.sv
// Top level of the hall pulse counter with shared lockout.
//
// Usage: input transactions on in_i carry either a timer tick (command 0) or a
// falling edge on one channel (command 1) together with the current pin
// levels. Every input transaction yields exactly one result transaction on
// out_o with the pulse count, remaining value, sticky output and lock flag.
// Registers threshold, confirm_ticks and lockout_ticks are written over the
// APB-style port at byte addresses 0, 4 and 8; write them only while idle.
// Sequencing: one channel unit is shared by all channels. An edge
// transaction passes through accept, arm and finish before its result is
// registered; a tick transaction passes through accept, one visit per
// channel and finish, since the unit visits one channel per cycle in order.
// in_i.ready is high only while the sequencer is idle, so a new transaction
// is taken only after the last one has left its finish state.
// The result sits in an output register: a new transaction is taken while an
// earlier result still waits, and the sequencer holds in its finish state
// only if the receiver stalls with the output register still full.
// Reset clears all channel state, the counters, the lock, the output latch
// and loads the register reset values; no clearing pass is needed.
module hall_pulse_counter_with_lockout (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  hpc_in_if.sink                     in_i,
  hpc_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hpc_pkg::AddrW-1:0]  paddr,
  input  logic [hpc_pkg::DataW-1:0]  pwdata,
  output logic [hpc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import hpc_pkg::*;

  localparam logic [IdxW-1:0] IdxLast = IdxW'(Channels - 1);

  // Configuration registers
  logic [CountW-1:0] thr_q;
  logic [TickW-1:0]  confirm_q;
  logic [TickW-1:0]  lockout_q;

  // Sequencer
  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q;
  logic [Channels-1:0] pin_q;
  logic              edge_ok_q;
  logic              in_take;
  logic              out_load;

  // Channel and shared state
  logic [Channels-1:0] armed_q;
  logic [TickW-1:0]    tick_q [Channels];
  logic                lock_q;
  logic [CountW-1:0]   pulses_q;
  logic                latch_q;
  logic [CountW-1:0]   shown_q;
  logic                updated_q;

  // Output register
  logic              out_valid_q;
  logic [CountW-1:0] out_rem_q;
  logic              out_upd_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_lvl_q;
  logic              out_lock_q;

  // Shared channel unit
  logic [TickW-1:0]  tick_cur;
  logic [TickW-1:0]  tick_inc;
  logic [CountW:0]   pulse_nx;
  logic [CountW:0]   thr_ext;
  logic [CountW-1:0] rem_val;
  logic              wrap;
  logic              confirm_hit;
  logic              release_hit;
  logic              level;
  logic              cfg_wr;

  // APB: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      RegThreshold: prdata = DataW'(thr_q);
      RegConfirm:   prdata = DataW'(confirm_q);
      RegLockout:   prdata = DataW'(lockout_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ThresholdRst;
      confirm_q <= ConfirmRst;
      lockout_q <= LockoutRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegThreshold: thr_q     <= pwdata[CountW-1:0];
        RegConfirm:   confirm_q <= pwdata[TickW-1:0];
        RegLockout:   lockout_q <= pwdata[TickW-1:0];
        default:      ;
      endcase
    end
  end

  // Shared unit: advance one channel's tick count and work out the pulse update
  always_comb begin
    tick_cur    = tick_q[idx_q];
    tick_inc    = (tick_cur == TickMax) ? tick_cur : tick_cur + 1'b1;
    pulse_nx    = {1'b0, pulses_q} + 1'b1;
    thr_ext     = {1'b0, thr_q};
    rem_val     = (pulse_nx > thr_ext) ? '0 : CountW'(thr_ext - pulse_nx);
    wrap        = (pulse_nx >= thr_ext);
    confirm_hit = !lock_q && (tick_inc >= confirm_q);
    release_hit = lock_q && (tick_inc >= lockout_q);
    level       = pin_q[idx_q];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          state_d = (in_i.command == CmdEdge) ? StEdge : StVisit;
        end
      end
      StEdge:  state_d = StDone;
      StVisit: begin
        if (idx_q == IdxLast) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_i.ready = (state_q == StIdle);
    out_load   = (state_q == StDone) && (!out_valid_q || out_o.ready);
  end

  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Channel state: arm on edge, visit one channel per cycle on tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      pin_q     <= '0;
      edge_ok_q <= 1'b0;
      armed_q   <= '0;
      for (int i = 0; i < Channels; i++) begin
        tick_q[i] <= '0;
      end
      lock_q    <= 1'b0;
      pulses_q  <= '0;
      latch_q   <= 1'b0;
      shown_q   <= '0;
      updated_q <= 1'b0;
    end else begin
      priority case (1'b1)
        in_take: begin
          updated_q <= 1'b0;
          edge_ok_q <= (int'(in_i.channel) < Channels);
          idx_q     <= (in_i.command == CmdEdge) ? IdxW'(in_i.channel) : '0;
          pin_q     <= Channels'({{Channels{1'b0}}, in_i.pin_levels});
        end
        (state_q == StEdge): begin
          if (edge_ok_q && !armed_q[idx_q]) begin
            armed_q[idx_q] <= 1'b1;
            tick_q[idx_q]  <= '0;
            lock_q         <= 1'b0;
          end
        end
        (state_q == StVisit): begin
          idx_q <= idx_q + 1'b1;
          if (armed_q[idx_q]) begin
            if (confirm_hit) begin
              if (!level) begin
                tick_q[idx_q] <= tick_inc;
                shown_q       <= rem_val;
                pulses_q      <= wrap ? '0 : pulse_nx[CountW-1:0];
                latch_q       <= latch_q | wrap;
                lock_q        <= 1'b1;
                updated_q     <= 1'b1;
              end else begin
                // glitch: drop the channel
                tick_q[idx_q]  <= '0;
                armed_q[idx_q] <= 1'b0;
              end
            end else if (release_hit) begin
              lock_q         <= 1'b0;
              tick_q[idx_q]  <= '0;
              armed_q[idx_q] <= 1'b0;
            end else begin
              tick_q[idx_q] <= tick_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rem_q  <= shown_q;
      out_upd_q  <= updated_q;
      out_cnt_q  <= pulses_q;
      out_lvl_q  <= latch_q;
      out_lock_q <= lock_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.remaining         = out_rem_q;
  assign out_o.remaining_updated = out_upd_q;
  assign out_o.pulse_count       = out_cnt_q;
  assign out_o.output_level      = out_lvl_q;
  assign out_o.lock_active       = out_lock_q;

  `include "hall_pulse_counter_with_lockout_assert.svh"

  `HPC_ASSERT_NEXT(a_accept_leaves_idle, in_take, state_q != StIdle, "accept did not start work")
  `HPC_ASSERT_NEXT(a_visit_advance, state_q == StVisit && idx_q != IdxLast, state_q == StVisit && idx_q == $past(idx_q) + 1'b1, "channel visit skipped")
  `HPC_ASSERT_IMPLY(a_lock_set_by_count, lock_q && !$past(lock_q), $past(state_q) == StVisit, "lock set outside a visit")
  `HPC_ASSERT_NEXT(a_edge_clears_lock, state_q == StEdge && edge_ok_q && !armed_q[idx_q], !lock_q, "arming edge left the lock set")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the hall pulse counter with shared lockout.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpc_pkg::*;

  // Run limits
  localparam int CycleLimit  = 500_000;
  localparam int PrintLimit  = 40;
  localparam int PhaseItems  = 90;
  localparam int SatTicks    = 1030;
  localparam logic [1:0] RegSpare = 2'd3;

  // One result transaction as the block reports it
  typedef struct packed {
    logic [CountW-1:0] remaining;
    logic              updated;
    logic [CountW-1:0] pulse_count;
    logic              out_level;
    logic              lock;
  } hall_result_t;

  // One row of the directed table; want is used only where typed is set
  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [ChanW-1:0] chan;
    logic [PinW-1:0]  pins;
    bit               typed;
    hall_result_t     want;
  } stim_row_t;

  // One register setting
  typedef struct {
    logic [CountW-1:0] thr;
    logic [TickW-1:0]  conf;
    logic [TickW-1:0]  lockout;
  } setting_t;

  localparam hall_result_t Quiet = '0;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  hpc_in_if  in_if ();
  hpc_out_if out_if ();

  hall_pulse_counter_with_lockout uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and register copies
  logic              armed_q [Channels];
  logic [TickW-1:0]  ticks_q [Channels];
  logic              lock_q;
  logic [CountW-1:0] pulses_q;
  logic              latch_q;
  logic [CountW-1:0] shown_q;
  logic [CountW-1:0] thr_cfg;
  logic [TickW-1:0]  confirm_cfg;
  logic [TickW-1:0]  lockout_cfg;

  hall_result_t due_results [$];
  bit           steady;
  int           mismatch_total;
  int           item_total;
  int           setting_total;
  int           pulse_total;
  int           release_total;
  int           cycle_count;

  // Gap before the next transaction on either side; zero during steady stretches
  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_total < PrintLimit) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_total++;
  endtask

  // Update the register copies the way a bus write does
  function automatic void set_reg(input logic [1:0] idx, input logic [DataW-1:0] val);
    case (idx)
      RegThreshold: thr_cfg = val[CountW-1:0];
      RegConfirm:   confirm_cfg = val[TickW-1:0];
      RegLockout:   lockout_cfg = val[TickW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the counter state by one transaction and return its result
  function automatic hall_result_t predict_count(input logic [CmdW-1:0] cmd,
                                                 input logic [ChanW-1:0] chan,
                                                 input logic [PinW-1:0] pins);
    hall_result_t res;
    int           nxt;
    bit           counted;
    counted = 1'b0;
    if (cmd == CmdEdge) begin
      // Arm an idle channel; an armed one keeps its count
      if (int'(chan) < Channels && !armed_q[chan]) begin
        armed_q[chan] = 1'b1;
        ticks_q[chan] = '0;
        lock_q        = 1'b0;
      end
    end else begin
      // Visit the channels in order
      for (int c = 0; c < Channels; c++) begin
        if (armed_q[c]) begin
          if (ticks_q[c] != TickMax) ticks_q[c] = ticks_q[c] + 1'b1;
          if (!lock_q && ticks_q[c] >= confirm_cfg) begin
            if (!pins[c]) begin
              nxt     = int'(pulses_q) + 1;
              shown_q = (nxt > int'(thr_cfg)) ? '0 : CountW'(int'(thr_cfg) - nxt);
              if (nxt >= int'(thr_cfg)) begin
                nxt     = 0;
                latch_q = 1'b1;
              end
              pulses_q = CountW'(nxt);
              lock_q   = 1'b1;
              counted  = 1'b1;
              pulse_total++;
            end else begin
              // Pin already high again: drop the edge as a glitch
              ticks_q[c] = '0;
              armed_q[c] = 1'b0;
            end
          end else if (lock_q && ticks_q[c] >= lockout_cfg) begin
            lock_q     = 1'b0;
            ticks_q[c] = '0;
            armed_q[c] = 1'b0;
            release_total++;
          end
        end
      end
    end
    res.remaining   = shown_q;
    res.updated     = counted;
    res.pulse_count = pulses_q;
    res.out_level   = latch_q;
    res.lock        = lock_q;
    return res;
  endfunction

  // Send one input transaction and queue what it should produce
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [ChanW-1:0] chan,
                           input logic [PinW-1:0] pins, input bit typed,
                           input hall_result_t want);
    int           gap;
    hall_result_t res;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.channel    <= chan;
    in_if.pin_levels <= pins;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    res = predict_count(cmd, chan, pins);
    due_results.push_back(typed ? want : res);
    item_total++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  // Bus write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Bus read
  task automatic read_reg(input logic [1:0] idx, output logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register and read it back
  task automatic program_reg(input logic [1:0] idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] rd;
    write_reg(idx, val);
    read_reg(idx, rd);
    if (rd !== val) report_mismatch("register readback", int'(rd), int'(val));
  endtask

  task automatic apply_setting(input setting_t s);
    program_reg(RegThreshold, DataW'(s.thr));
    program_reg(RegConfirm, DataW'(s.conf));
    program_reg(RegLockout, DataW'(s.lockout));
    setting_total++;
  endtask

  // Mostly edge-then-ticks bursts with random content, some plain noise
  task automatic run_random(input int count);
    int               sent;
    int               len;
    bit               clean;
    logic [ChanW-1:0] chan;
    logic [PinW-1:0]  pins;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 29) == 0) steady = !steady;
      if ($urandom_range(0, 59) == 0) drain_results();
      if ($urandom_range(0, 4) == 0) begin
        send_item(CmdW'($urandom_range(0, 1)), ChanW'($urandom_range(0, 3)),
                  PinW'($urandom_range(0, 15)), 1'b0, Quiet);
        sent++;
      end else begin
        chan  = ChanW'($urandom_range(0, 3));
        clean = ($urandom_range(0, 2) != 0);
        send_item(CmdEdge, chan, PinW'($urandom_range(0, 15)), 1'b0, Quiet);
        sent++;
        len = $urandom_range(1, 30);
        for (int k = 0; k < len && sent < count; k++) begin
          pins       = PinW'($urandom_range(0, 15));
          pins[chan] = clean ? 1'b0 : 1'($urandom_range(0, 1));
          send_item(CmdTick, ChanW'($urandom_range(0, 3)), pins, 1'b0, Quiet);
          sent++;
        end
      end
    end
  endtask

  // Result side: random stalls, compare every transaction with the oldest expectation
  initial begin : result_sink
    hall_result_t got;
    hall_result_t want;
    int           stall;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
      got.remaining   = out_if.remaining;
      got.updated     = out_if.remaining_updated;
      got.pulse_count = out_if.pulse_count;
      got.out_level   = out_if.output_level;
      got.lock        = out_if.lock_active;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result transaction", int'(got), 0);
      end else begin
        want = due_results.pop_front();
        if (got.remaining !== want.remaining)
          report_mismatch("remaining", int'(got.remaining), int'(want.remaining));
        if (got.updated !== want.updated)
          report_mismatch("remaining_updated", int'(got.updated), int'(want.updated));
        if (got.pulse_count !== want.pulse_count)
          report_mismatch("pulse_count", int'(got.pulse_count), int'(want.pulse_count));
        if (got.out_level !== want.out_level)
          report_mismatch("output_level", int'(got.out_level), int'(want.out_level));
        if (got.lock !== want.lock)
          report_mismatch("lock_active", int'(got.lock), int'(want.lock));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t        dir_rows [23];
    setting_t         plan [7];
    logic [DataW-1:0] rd;
    logic [PinW-1:0]  pins;
    logic [ChanW-1:0] sat_ch;

    // Drive every input to a known value
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CmdTick;
    in_if.channel    <= '0;
    in_if.pin_levels <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    mismatch_total   = 0;
    item_total       = 0;
    setting_total    = 0;
    pulse_total      = 0;
    release_total    = 0;
    steady           = 1'b0;

    // Predictor reset state
    for (int c = 0; c < Channels; c++) begin
      armed_q[c] = 1'b0;
      ticks_q[c] = '0;
    end
    lock_q      = 1'b0;
    pulses_q    = '0;
    latch_q     = 1'b0;
    shown_q     = '0;
    thr_cfg     = ThresholdRst;
    confirm_cfg = ConfirmRst;
    lockout_cfg = LockoutRst;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers come up with their reset values
    read_reg(RegThreshold, rd);
    if (rd !== DataW'(ThresholdRst)) report_mismatch("threshold reset", int'(rd), 20);
    read_reg(RegConfirm, rd);
    if (rd !== DataW'(ConfirmRst)) report_mismatch("confirm_ticks reset", int'(rd), 3);
    read_reg(RegLockout, rd);
    if (rd !== DataW'(LockoutRst)) report_mismatch("lockout_ticks reset", int'(rd), 500);
    setting_total = 1;

    // Directed part under reset settings: arm, re-arm, confirm, lock, glitches
    dir_rows = '{
      '{CmdTick, 2'd3, 4'hF, 1'b1, Quiet},
      '{CmdEdge, 2'd0, 4'hF, 1'b1, Quiet},
      '{CmdEdge, 2'd0, 4'h0, 1'b1, Quiet},
      '{CmdTick, 2'd0, 4'h0, 1'b1, Quiet},
      '{CmdTick, 2'd1, 4'h0, 1'b1, Quiet},
      '{CmdTick, 2'd2, 4'hE, 1'b1, '{7'd19, 1'b1, 7'd1, 1'b0, 1'b1}},
      '{CmdTick, 2'd0, 4'hF, 1'b1, '{7'd19, 1'b0, 7'd1, 1'b0, 1'b1}},
      '{CmdEdge, 2'd1, 4'h0, 1'b1, '{7'd19, 1'b0, 7'd1, 1'b0, 1'b0}},
      '{CmdTick, 2'd0, 4'hD, 1'b0, Quiet},
      '{CmdEdge, 2'd2, 4'hF, 1'b0, Quiet},
      '{CmdTick, 2'd1, 4'hF, 1'b0, Quiet},
      '{CmdTick, 2'd2, 4'hF, 1'b0, Quiet},
      '{CmdTick, 2'd3, 4'hF, 1'b0, Quiet},
      '{CmdEdge, 2'd3, 4'h0, 1'b0, Quiet},
      '{CmdTick, 2'd0, 4'h0, 1'b0, Quiet},
      '{CmdTick, 2'd0, 4'h0, 1'b0, Quiet},
      '{CmdTick, 2'd0, 4'h0, 1'b0, Quiet},
      '{CmdEdge, 2'd3, 4'h7, 1'b0, Quiet},
      '{CmdEdge, 2'd2, 4'h8, 1'b0, Quiet},
      '{CmdTick, 2'd2, 4'h0, 1'b0, Quiet},
      '{CmdTick, 2'd1, 4'h5, 1'b0, Quiet},
      '{CmdTick, 2'd3, 4'hA, 1'b0, Quiet},
      '{CmdTick, 2'd0, 4'hF, 1'b0, Quiet}
    };
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].chan, dir_rows[i].pins, dir_rows[i].typed,
                dir_rows[i].want);
    end

    // Random phases: zero, large then lowered threshold, all ones, near-max, random
    plan = '{
      '{7'd0,   10'd0, 10'd0},
      '{7'd99,  10'd1, 10'd3},
      '{7'd4,   10'd2, 10'd6},
      '{7'd1,   10'd1, 10'd1},
      '{7'd127, 10'd3, 10'd1023},
      '{7'd0,   10'd1, 10'd1},
      '{7'd0,   10'd1, 10'd1}
    };
    for (int p = 5; p < 7; p++) begin
      plan[p].thr     = CountW'($urandom_range(0, 12));
      plan[p].conf    = TickW'($urandom_range(1, 5));
      plan[p].lockout = TickW'($urandom_range(1, 25));
    end
    foreach (plan[p]) begin
      drain_results();
      apply_setting(plan[p]);
      // The spare address must not disturb anything
      if (p == 2) write_reg(RegSpare, DataW'($urandom_range(0, 1023)));
      steady = ($urandom_range(0, 3) == 0);
      run_random(PhaseItems);
    end

    // Hold one channel low long enough for its tick counter to saturate
    drain_results();
    apply_setting('{7'd3, 10'd1023, 10'd1023});
    steady = 1'b0;
    sat_ch = ChanW'($urandom_range(0, 3));
    send_item(CmdEdge, sat_ch, PinW'($urandom_range(0, 15)), 1'b0, Quiet);
    for (int k = 0; k < SatTicks; k++) begin
      pins         = PinW'($urandom_range(0, 15));
      pins[sat_ch] = 1'b0;
      send_item(CmdTick, ChanW'($urandom_range(0, 3)), pins, 1'b0, Quiet);
    end

    // Let the last results come back, then settle
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d input transactions under %0d register settings.",
             item_total, setting_total);
    $display("Predicted %0d counted pulses and %0d lock releases; %0d mismatches.",
             pulse_total, release_total, mismatch_total);
    if (mismatch_total == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/hpc_pkg.sv
design/hpc_if.sv
design/hall_pulse_counter_with_lockout.sv
test/tb_top.sv
